>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Asserts that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Asserts an implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

>>> rtl/rmg_pkg.sv
// ----------------------------------------------------------------------------
// Row maze generator package
// Shared widths and constants of the row maze generator.
// ----------------------------------------------------------------------------
package rmg_pkg;
  localparam int unsigned LabelW = 5;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned JoinW  = 31;
  localparam int unsigned CarveW = 32;
  localparam logic [CfgW-1:0] ColsReset = 6'd32;
endpackage

>>> rtl/row_maze_generator_top.sv
// ----------------------------------------------------------------------------
// Row maze generator
// Builds one maze row per request with Eller's algorithm.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// in      | in_valid_i, in_stall_o, join/carve/last   | request in
// out     | out_valid_o, out_stall_i, walls, done     | result out
// cfg     | cfg_we_i, cfg_data_i                      | register write
// For W columns a request runs a label pass, a fresh-label pass, a join pass,
// a scan pass and a carve pass. The label, fresh-label, scan and carve passes
// each walk the W columns; the join pass decides each column pair and, for every
// pair that joins, walks the whole row to relabel it. The last row skips scan and carve.
// Reset clears labels and assignment flags and sets the column count to 32.
// A result waits in its output register while the output is stalled; the
// block takes the next request once the result register is free.
module row_maze_generator_top #(
  parameter int unsigned MAX_COLUMNS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rmg_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rmg_pkg::JoinW-1:0]    join_bits_i,
  input  logic [rmg_pkg::CarveW-1:0]   carve_bits_i,
  input  logic                         last_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rmg_pkg::JoinW-1:0]    right_walls_o,
  output logic [rmg_pkg::CarveW-1:0]   down_walls_o,
  output logic                         maze_done_o
);
  localparam int unsigned NCol = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;
  localparam int unsigned IdxW = $clog2(NCol);
  localparam int unsigned CntW = $clog2(NCol + 1);
  localparam int unsigned LW   = rmg_pkg::LabelW;

  typedef enum logic [2:0] {
    S_IDLE, S_USED, S_FRESH, S_JOIN, S_SCAN, S_CARVE, S_DONE
  } state_e;

  state_e state_q;
  logic [LW-1:0] lab_q [NCol];
  logic [NCol-1:0] asg_q;
  logic [rmg_pkg::CfgW-1:0] cols_q;
  logic [31:0] used_q, has_q, carved_q;
  logic [rmg_pkg::JoinW-1:0] join_q, right_q;
  logic last_q;
  logic [CntW-1:0] w_q;
  logic [IdxW-1:0] i_q, j_q;
  logic [LW-1:0] keep_q, gone_q;
  logic [31:0] seen_q;

  // Clamped column count.
  logic [CntW-1:0] w_c;
  always_comb begin
    priority if (cols_q < 6'd2) w_c = CntW'(2);
    else if (32'(cols_q) > NCol) w_c = CntW'(NCol);
    else w_c = CntW'(cols_q);
  end

  // Lowest free label.
  logic [LW-1:0] free_c;
  always_comb begin
    free_c = '0;
    for (int k = 31; k >= 0; k--) begin
      if (!used_q[k]) free_c = LW'(k);
    end
  end

  logic [CntW-1:0] i_ext, j_ext;
  assign i_ext = CntW'(i_q);
  assign j_ext = CntW'(j_q);

  assign in_stall_o = (state_q != S_IDLE) || out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      asg_q <= '0;
      cols_q <= rmg_pkg::ColsReset;
      out_valid_o <= 1'b0;
      for (int k = 0; k < NCol; k++) lab_q[k] <= '0;
    end else begin
      if (cfg_we_i) cols_q <= cfg_data_i;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            join_q <= join_bits_i;
            carved_q <= carve_bits_i;
            last_q <= last_row_i;
            w_q <= w_c;
            used_q <= '0;
            i_q <= '0;
            for (int k = 0; k < NCol; k++) begin
              if (CntW'(k) >= w_c) begin
                asg_q[k] <= 1'b0;
                lab_q[k] <= '0;
              end
            end
            state_q <= S_USED;
          end
        end
        S_USED: begin
          if (asg_q[i_q]) used_q[lab_q[i_q]] <= 1'b1;
          if (i_ext == w_q - 1'b1) begin
            i_q <= '0;
            state_q <= S_FRESH;
          end else i_q <= i_q + 1'b1;
        end
        S_FRESH: begin
          if (!asg_q[i_q]) begin
            lab_q[i_q] <= free_c;
            asg_q[i_q] <= 1'b1;
            used_q[free_c] <= 1'b1;
          end
          if (i_ext == w_q - 1'b1) begin
            i_q <= IdxW'(1);
            j_q <= '0;
            right_q <= '0;
            state_q <= S_JOIN;
          end else i_q <= i_q + 1'b1;
        end
        S_JOIN: begin
          // First sweep cycle of a pair decides; then relabel column by column.
          if (j_q == '0) begin
            keep_q <= lab_q[i_q - 1'b1];
            gone_q <= lab_q[i_q];
          end
          if (j_q == '0 && (lab_q[i_q - 1'b1] == lab_q[i_q] ||
              (!last_q && !join_q[i_q - 1'b1]))) begin
            right_q[i_q - 1'b1] <= 1'b1;
            if (i_ext == w_q - 1'b1) begin
              i_q <= '0;
              seen_q <= '0;
              has_q <= '0;
              state_q <= last_q ? S_DONE : S_SCAN;
            end else i_q <= i_q + 1'b1;
          end else begin
            if (j_q != '0 && lab_q[j_q] == gone_q)
              lab_q[j_q] <= keep_q;
            if (j_q == '0 && lab_q[0] == lab_q[i_q]) lab_q[0] <= lab_q[i_q - 1'b1];
            if (j_ext == w_q - 1'b1) begin
              j_q <= '0;
              if (i_ext == w_q - 1'b1) begin
                i_q <= '0;
                seen_q <= '0;
                has_q <= '0;
                state_q <= last_q ? S_DONE : S_SCAN;
              end else i_q <= i_q + 1'b1;
            end else j_q <= j_q + 1'b1;
          end
        end
        S_SCAN: begin
          // Which sets already have a requested passage.
          if (carved_q[i_q]) has_q[lab_q[i_q]] <= 1'b1;
          if (i_ext == w_q - 1'b1) begin
            i_q <= IdxW'(w_q - 1'b1);
            state_q <= S_CARVE;
          end else i_q <= i_q + 1'b1;
        end
        S_CARVE: begin
          // Right to left: first sighting of a set is its rightmost column.
          if (!seen_q[lab_q[i_q]]) begin
            seen_q[lab_q[i_q]] <= 1'b1;
            if (!has_q[lab_q[i_q]]) carved_q[i_q] <= 1'b1;
          end
          if (i_q == '0) state_q <= S_DONE;
          else i_q <= i_q - 1'b1;
        end
        default: begin
          right_walls_o <= right_q & JoinW_mask(w_q);
          maze_done_o <= last_q;
          if (last_q) begin
            down_walls_o <= '1;
            asg_q <= '0;
            for (int k = 0; k < NCol; k++) lab_q[k] <= '0;
          end else begin
            for (int k = 0; k < 32; k++)
              down_walls_o[k] <= !(CntW'(k) < w_q && carved_q[k]);
            for (int k = 0; k < NCol; k++) begin
              if (CntW'(k) < w_q) begin
                asg_q[k] <= carved_q[k];
                if (!carved_q[k]) lab_q[k] <= '0;
              end
            end
          end
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  function automatic logic [rmg_pkg::JoinW-1:0] JoinW_mask(input logic [CntW-1:0] w);
    logic [rmg_pkg::JoinW-1:0] m;
    m = '0;
    for (int k = 0; k < 31; k++) if (CntW'(k + 1) < w) m[k] = 1'b1;
    return m;
  endfunction
endmodule

>>> rtl/rmg_checker.sv
// ----------------------------------------------------------------------------
// Row maze generator checker
// Port-level checks of the row maze generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rmg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] down_walls_o,
  input logic        maze_done_o
);
  `ASSERT_IMPL(a_done_down, clk_i, rst_ni, out_valid_o && maze_done_o,
    down_walls_o == 32'hFFFFFFFF, "last row must have all down walls")
  `ASSERT_IMPL(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o,
    ##1 in_stall_o, "block must stall after taking a request")
  `ASSERT_IMPL(a_stall_while_out, clk_i, rst_ni, out_valid_o,
    in_stall_o, "no request while a result waits")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    ##1 out_valid_o, "stalled result must stay")
endmodule

bind row_maze_generator_top rmg_checker u_rmg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .down_walls_o(down_walls_o), .maze_done_o(maze_done_o)
);
